// File: sv/packet_header_varint_encoder_assert.svh
// assertion macros for the packet header varint encoder
// no dependencies; included by the top level only
`ifndef PACKET_HEADER_VARINT_ENCODER_ASSERT_SVH
`define PACKET_HEADER_VARINT_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication under reset
`define PHVE_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("phve assertion failed");
// next-cycle implication under reset
`define PHVE_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("phve assertion failed");
`else
`define PHVE_ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define PHVE_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// File: sv/phve_pkg.sv
// shared types and constants for the packet header varint encoder
// no dependencies
`default_nettype none
package phve_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 28;
    localparam int PLAIN_BYTES = 3;
    localparam int HDR_W       = 3 * BYTE_W + 2 * LEN_W;

    localparam logic [BYTE_W-1:0] DATA_MASK  = 8'h7f;
    localparam logic [BYTE_W-1:0] CONT_BIT   = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_RESET = 8'h80;

    // one packet header as held in the input register
    typedef struct packed {
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] options;
        logic [BYTE_W-1:0] sequence_req;
        logic [LEN_W-1:0]  pkt_len;
        logic [LEN_W-1:0]  chunk_off;
    } t_hdr;

endpackage
`default_nettype wire

// File: sv/packet_header_varint_encoder.sv
// packet header varint encoder: input register, encoder, shifting result buffer
// a header's first word shows when the input register loads the result buffer
// throughput: one output word per ready cycle, 4 to 3+2*VARINT_MAX_BYTES+1 words a header;
// the result buffer sets the rate, the input register takes the next header meanwhile
// reset: empties the input register and result buffer, chunk flag mask returns to 0x80
`default_nettype none
`include "packet_header_varint_encoder_assert.svh"
module packet_header_varint_encoder #(
    parameter int VARINT_MAX_BYTES = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration: chunk_flag_mask
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [phve_pkg::BYTE_W-1:0]   i_cfg_data,
    // header in
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // command[7:0], options[15:8], sequence_req[23:16],
    // pkt_len[51:24], chunk_off[79:52]
    input  wire logic [phve_pkg::HDR_W-1:0]    i_s_axis_tdata,
    // byte run out
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // out_byte[7:0]
    output logic [phve_pkg::BYTE_W-1:0]        o_m_axis_tdata,
    // last_byte
    output logic                               o_m_axis_tlast
);

    localparam int MAXB = phve_pkg::PLAIN_BYTES + 2 * VARINT_MAX_BYTES + 1;
    localparam int CW   = $clog2(MAXB + 1);

    logic [phve_pkg::BYTE_W-1:0]           r_chunk_mask;
    phve_pkg::t_hdr                        r_hdr;
    logic                                  r_hdr_valid;
    logic                                  n_hdr_valid;
    logic                                  w_accept;
    logic                                  w_can_load;
    logic                                  w_load;
    logic [MAXB-1:0][phve_pkg::BYTE_W-1:0] w_bytes;
    logic [CW-1:0]                         w_count;
    logic                                  w_mid_word;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_mask <= phve_pkg::MASK_RESET;
        end else if (i_cfg_valid) begin
            r_chunk_mask <= i_cfg_data;
        end
    end

    // input register handshake
    assign w_load          = r_hdr_valid && w_can_load;
    assign o_s_axis_tready = !r_hdr_valid || w_can_load;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_hdr_valid = r_hdr_valid;
        if (w_accept) begin
            n_hdr_valid = 1'b1;
        end else if (w_load) begin
            n_hdr_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_valid <= 1'b0;
        end else begin
            r_hdr_valid <= n_hdr_valid;
        end
    end

    // header fields
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hdr.command      <= i_s_axis_tdata[7:0];
            r_hdr.options      <= i_s_axis_tdata[15:8];
            r_hdr.sequence_req <= i_s_axis_tdata[23:16];
            r_hdr.pkt_len      <= i_s_axis_tdata[51:24];
            r_hdr.chunk_off    <= i_s_axis_tdata[79:52];
        end
    end

    // encode the held header
    phve_encode #(
        .VMAX (VARINT_MAX_BYTES),
        .MAXB (MAXB),
        .CW   (CW)
    ) u_encode (
        .i_hdr        (r_hdr),
        .i_chunk_mask (r_chunk_mask),
        .o_bytes      (w_bytes),
        .o_count      (w_count)
    );

    // shift the run out
    phve_serial #(
        .MAXB (MAXB),
        .CW   (CW)
    ) u_serial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_bytes    (w_bytes),
        .i_count    (w_count),
        .o_can_load (w_can_load),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_data     (o_m_axis_tdata),
        .o_last     (o_m_axis_tlast)
    );

    // a word taken that is not the last of its run
    assign w_mid_word = o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast;

    // checks
    `PHVE_ASSERT_NEXT(a_load_fills, i_clk, i_rst_n, w_load, o_m_axis_tvalid)
    `PHVE_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, w_mid_word, o_m_axis_tvalid)
    `PHVE_ASSERT_NEXT(a_accept_holds, i_clk, i_rst_n, w_accept, r_hdr_valid)
    `PHVE_ASSERT_IMPLY(a_load_needs_hdr, i_clk, i_rst_n, w_load, r_hdr_valid && w_can_load)

endmodule
`default_nettype wire

// File: sv/phve_encode.sv
// combinational header encoder: plain bytes, length varint, pad, offset varint
// depends on phve_pkg
`default_nettype none
module phve_encode #(
    parameter int VMAX = 4,
    parameter int MAXB = phve_pkg::PLAIN_BYTES + 2 * VMAX + 1,
    parameter int CW   = $clog2(MAXB + 1)
) (
    input  var phve_pkg::t_hdr                           i_hdr,
    input  wire logic [phve_pkg::BYTE_W-1:0]             i_chunk_mask,
    output logic [MAXB-1:0][phve_pkg::BYTE_W-1:0]        o_bytes,
    output logic [CW-1:0]                                o_count
);

    localparam int LW  = $clog2(VMAX + 1);
    localparam int LIW = $clog2(VMAX);

    logic [VMAX-1:0][phve_pkg::BYTE_W-1:0] len_b;
    logic [VMAX-1:0][phve_pkg::BYTE_W-1:0] off_b;
    logic [2:0][phve_pkg::BYTE_W-1:0]      plain_b;
    logic [LW-1:0]                         nl;
    logic [LW-1:0]                         nc;
    logic                                  chunked;
    logic                                  off_nz;
    logic [CW-1:0]                         par_cnt;
    logic                                  odd;

    assign plain_b[0] = i_hdr.command;
    assign plain_b[1] = i_hdr.options;
    assign plain_b[2] = i_hdr.sequence_req;

    assign chunked = (i_hdr.options & i_chunk_mask) != '0;
    assign off_nz  = i_hdr.chunk_off != '0;

    // varint groups with continuation when higher groups are nonzero
    always_comb begin
        for (int i = 0; i < VMAX; i++) begin
            len_b[i] = (phve_pkg::BYTE_W'(i_hdr.pkt_len >> (7 * i)) & phve_pkg::DATA_MASK)
                     | (((i_hdr.pkt_len >> (7 * (i + 1))) != '0) ? phve_pkg::CONT_BIT
                                                                 : '0);
            off_b[i] = (phve_pkg::BYTE_W'(i_hdr.chunk_off >> (7 * i)) & phve_pkg::DATA_MASK)
                     | (((i_hdr.chunk_off >> (7 * (i + 1))) != '0) ? phve_pkg::CONT_BIT
                                                                   : '0);
        end
    end

    // varint byte counts, capped at VMAX
    always_comb begin
        nl = LW'(1);
        nc = LW'(1);
        for (int i = 1; i < VMAX; i++) begin
            if ((i_hdr.pkt_len >> (7 * i)) != '0) nl = LW'(i + 1);
            if ((i_hdr.chunk_off >> (7 * i)) != '0) nc = LW'(i + 1);
        end
    end

    // parity count: zero offset does not count
    assign par_cnt = CW'(phve_pkg::PLAIN_BYTES) + CW'(nl)
                   + ((chunked && off_nz) ? CW'(nc) : CW'(0));
    assign odd = par_cnt[0];

    assign o_count = CW'(phve_pkg::PLAIN_BYTES) + CW'(nl) + CW'(odd)
                   + (chunked ? CW'(nc) : CW'(0));

    // place each output byte
    always_comb begin
        int j;
        int m;
        for (int k = 0; k < MAXB; k++) begin
            j = k - phve_pkg::PLAIN_BYTES;
            m = j - int'(nl) - int'(odd);
            if (k < phve_pkg::PLAIN_BYTES) begin
                o_bytes[k] = plain_b[k];
            end else if (j < int'(nl)) begin
                o_bytes[k] = len_b[LIW'(j)];
                if (odd && (j == int'(nl) - 1)) o_bytes[k] = o_bytes[k] | phve_pkg::CONT_BIT;
            end else if (odd && (j == int'(nl))) begin
                o_bytes[k] = '0;
            end else if (chunked && (m < VMAX)) begin
                o_bytes[k] = off_b[LIW'(m)];
            end else begin
                o_bytes[k] = '0;
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/phve_serial.sv
// result buffer that shifts the encoded header out one word per cycle while the receiver is ready
// depends on phve_pkg
`default_nettype none
module phve_serial #(
    parameter int MAXB = 12,
    parameter int CW   = $clog2(MAXB + 1)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_load,
    input  wire logic [MAXB-1:0][phve_pkg::BYTE_W-1:0] i_bytes,
    input  wire logic [CW-1:0]                        i_count,
    output logic                                      o_can_load,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [phve_pkg::BYTE_W-1:0]               o_data,
    output logic                                      o_last
);

    logic [MAXB-1:0][phve_pkg::BYTE_W-1:0] r_bytes;
    logic [MAXB-1:0][phve_pkg::BYTE_W-1:0] n_bytes;
    logic [CW-1:0]                         r_left;
    logic [CW-1:0]                         n_left;

    assign o_valid    = r_left != '0;
    assign o_data     = r_bytes[0];
    assign o_last     = r_left == CW'(1);
    assign o_can_load = !o_valid || (i_ready && o_last);

    // load a new run or shift one word out
    always_comb begin
        n_bytes = r_bytes;
        n_left  = r_left;
        if (i_load) begin
            n_bytes = i_bytes;
            n_left  = i_count;
        end else if (o_valid && i_ready) begin
            n_bytes = {phve_pkg::BYTE_W'(0), r_bytes[MAXB-1:1]};
            n_left  = r_left - CW'(1);
        end
    end

    // remaining word count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    // payload words
    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

endmodule
`default_nettype wire

// File: verif/tb_packet_header_varint_encoder.sv
// testbench for packet_header_varint_encoder: directed and random header words in,
// byte runs checked against a behavioral encoder kept in the bench
// depends on phve_pkg and the packet_header_varint_encoder top level
module tb_packet_header_varint_encoder;

    localparam int VARINT_MAX_BYTES = 4;
    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 12;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int RX_HOLD_CYCLES   = 300;
    localparam int MAX_PRINTED      = 100;
    localparam int BW               = phve_pkg::BYTE_W;
    localparam int LW               = phve_pkg::LEN_W;

    localparam logic [BW-1:0] MASK_NONE = 8'h00;
    localparam logic [BW-1:0] MASK_ALL  = 8'hff;

    // one word of the byte run as it should leave the block
    typedef struct packed {
        logic [BW-1:0] out_byte;
        logic          last_byte;
    } t_run_word;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    logic                         i_clk           = 1'b0;
    logic                         i_rst_n         = 1'b0;
    logic                         i_cfg_valid     = 1'b0;
    logic [BW-1:0]                i_cfg_data      = '0;
    logic                         o_cfg_ready;
    logic                         i_s_axis_tvalid = 1'b0;
    logic                         o_s_axis_tready;
    logic [phve_pkg::HDR_W-1:0]   i_s_axis_tdata  = '0;
    logic                         o_m_axis_tvalid;
    logic                         i_m_axis_tready = 1'b0;
    logic [BW-1:0]                o_m_axis_tdata;
    logic                         o_m_axis_tlast;

    // headers waiting to be sent and bytes waiting to come out
    phve_pkg::t_hdr    hdr_q[$];
    t_run_word         run_word_q[$];
    logic [BW-1:0]     run_bytes[$];

    logic [BW-1:0]     chunk_mask  = phve_pkg::MASK_RESET;
    phve_pkg::t_hdr    offered_hdr;
    t_run_word         want_word;
    int                n_offered   = 0;
    int                n_taken     = 0;
    int                err_cnt     = 0;
    int                cycle_cnt   = 0;
    bit                sender_hold = 1'b0;
    int                burst_left  = 0;
    int                gap_left    = 0;
    int                rx_hold_req  = 0;
    int                rx_hold_left = 0;
    int                rx_mode_left = 0;
    int                rx_phase     = 0;
    t_rx_mode          rx_mode      = RX_ALWAYS;

    always #(CLK_HALF) i_clk = ~i_clk;

    packet_header_varint_encoder #(
        .VARINT_MAX_BYTES(VARINT_MAX_BYTES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    // number of varint bytes for a value, capped at the varint limit
    function automatic int varint_size(input logic [LW-1:0] v);
        int n;
        n = 1;
        v = v >> 7;
        while (v != '0 && n < VARINT_MAX_BYTES) begin
            n++;
            v = v >> 7;
        end
        return n;
    endfunction

    // little-endian base-128 bytes, continuation bit while more value is left
    function automatic void append_varint(input logic [LW-1:0] v);
        int n;
        logic [BW-1:0] b;
        n = varint_size(v);
        for (int i = 0; i < n; i++) begin
            b = {1'b0, v[6:0]};
            if (v > LW'(phve_pkg::DATA_MASK)) b = b | phve_pkg::CONT_BIT;
            run_bytes.push_back(b);
            v = v >> 7;
        end
    endfunction

    // expected byte run of one header
    function automatic void encode_header(input phve_pkg::t_hdr h);
        logic chunked;
        int count;
        chunked = (h.options & chunk_mask) != '0;
        run_bytes.delete();
        run_bytes.push_back(h.command);
        run_bytes.push_back(h.options);
        run_bytes.push_back(h.sequence_req);
        append_varint(h.pkt_len);
        count = phve_pkg::PLAIN_BYTES + varint_size(h.pkt_len);
        // a zero offset is still sent but does not count toward parity
        if (chunked && h.chunk_off != '0) count += varint_size(h.chunk_off);
        // odd count: stretch the length with an empty continuation byte
        if (count % 2 == 1) begin
            run_bytes[run_bytes.size()-1] = run_bytes[run_bytes.size()-1] | phve_pkg::CONT_BIT;
            run_bytes.push_back('0);
        end
        if (chunked) append_varint(h.chunk_off);
        foreach (run_bytes[k])
            run_word_q.push_back('{out_byte: run_bytes[k],
                                   last_byte: (k == run_bytes.size() - 1)});
    endfunction

    // values spread over every varint length, with zero and full-range picks
    function automatic logic [LW-1:0] rand_varint();
        logic [LW-1:0] v;
        case ($urandom_range(0, 5))
            0: v = LW'($urandom_range(0, 127));
            1: v = LW'($urandom_range(128, 16383));
            2: v = LW'($urandom_range(16384, 2097151));
            3: v = LW'($urandom_range(2097152, 268435455));
            4: v = '0;
            default: v = LW'($urandom);
        endcase
        return v;
    endfunction

    function automatic void queue_header(input logic [BW-1:0] cmd, opt, seq,
                                         input logic [LW-1:0] plen, coff);
        phve_pkg::t_hdr h;
        h.command      = cmd;
        h.options      = opt;
        h.sequence_req = seq;
        h.pkt_len      = plen;
        h.chunk_off    = coff;
        hdr_q.push_back(h);
    endfunction

    // random headers, about half of them with the current mask bits forced into options
    function automatic void queue_random(input int count);
        logic [BW-1:0] opt;
        repeat (count) begin
            opt = BW'($urandom);
            if ($urandom_range(0, 1) == 1) opt = opt | chunk_mask;
            queue_header(BW'($urandom), opt, BW'($urandom),
                         rand_varint(), rand_varint());
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (err_cnt < MAX_PRINTED) $display("cycle %0d: %s", cycle_cnt, what);
        err_cnt++;
    endtask

    // wait for an empty or held queue, each offered header taken and its bytes out
    task automatic wait_drained();
        do @(posedge i_clk);
        while (n_taken != n_offered || run_word_q.size() != 0 ||
               (hdr_q.size() != 0 && !sender_hold));
    endtask

    task automatic write_chunk_mask(input logic [BW-1:0] mask);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mask;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        chunk_mask = mask;
    endtask

    // header sender: bursts of random length, random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                encode_header(offered_hdr);
                n_taken++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0 || sender_hold || hdr_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else begin
                    offered_hdr = hdr_q.pop_front();
                    n_offered++;
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {offered_hdr.chunk_off, offered_hdr.pkt_len,
                                        offered_hdr.sequence_req, offered_hdr.options,
                                        offered_hdr.command};
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end
            end
        end
    end

    // byte receiver: stretches of stall patterns, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (rx_hold_req > 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 100);
            end else begin
                rx_mode_left--;
            end
            rx_phase++;
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: i_m_axis_tready <= 1'b1;
                    RX_COIN:   i_m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_m_axis_tready <= (rx_phase % 4 == 0);
                    default:   i_m_axis_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // byte checker against the oldest expected word
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (run_word_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", o_m_axis_tdata));
            end else begin
                want_word = run_word_q.pop_front();
                if (o_m_axis_tdata !== want_word.out_byte)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              o_m_axis_tdata, want_word.out_byte));
                if (o_m_axis_tlast !== want_word.last_byte)
                    report_mismatch($sformatf("last_byte %b, expected %b",
                                              o_m_axis_tlast, want_word.last_byte));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset mask: field extremes and every length size
        queue_header(8'h00, 8'h00, 8'h00, 28'h0000000, 28'h0000000);
        queue_header(8'hff, 8'hff, 8'hff, 28'hfffffff, 28'hfffffff);
        queue_header(8'h01, 8'h00, 8'h02, 28'h000007f, 28'h0000000);
        queue_header(8'h02, 8'h00, 8'h03, 28'h0000080, 28'h0000000);
        queue_header(8'h03, 8'h7f, 8'h04, 28'h0003fff, 28'h0000000);
        queue_header(8'h04, 8'h00, 8'h05, 28'h0004000, 28'h0000000);
        queue_header(8'h05, 8'h00, 8'h06, 28'h01fffff, 28'h0000000);
        queue_header(8'h06, 8'h00, 8'h07, 28'h0200000, 28'h0000000);
        // chunked with zero offset, even and odd counts
        queue_header(8'h07, 8'h80, 8'h08, 28'h000007f, 28'h0000000);
        queue_header(8'h08, 8'h80, 8'h09, 28'h0000080, 28'h0000000);
        queue_header(8'h80, 8'h80, 8'h80, 28'hfffffff, 28'h0000000);
        // chunked with nonzero offsets
        queue_header(8'h09, 8'h80, 8'h0a, 28'h0000005, 28'h0000001);
        queue_header(8'h0a, 8'h80, 8'h0b, 28'h0000005, 28'h0000080);
        queue_header(8'h0b, 8'hc1, 8'h0c, 28'h0004000, 28'h0200000);
        queue_header(8'h7f, 8'hfe, 8'h01, 28'h0003fff, 28'h000007f);
        queue_header(8'haa, 8'h80, 8'h55, 28'haaaaaaa, 28'h5555555);
        queue_header(8'h55, 8'h80, 8'haa, 28'h5555555, 28'haaaaaaa);
        // chunk bit clear: offset ignored
        queue_header(8'h0c, 8'h7f, 8'h0d, 28'h0000000, 28'hfffffff);

        // no options bit marks a chunk
        write_chunk_mask(MASK_NONE);
        queue_header(8'hff, 8'hff, 8'hff, 28'hfffffff, 28'hfffffff);
        queue_random(35);

        // any options bit marks a chunk; long receiver hold-off fills the block
        write_chunk_mask(MASK_ALL);
        queue_header(8'h00, 8'h01, 8'h00, 28'h0000080, 28'h0000000);
        queue_random(40);
        rx_hold_req = RX_HOLD_CYCLES;

        // random mask; sender pauses midway until the block is empty
        write_chunk_mask(BW'($urandom_range(1, 254)));
        queue_random(40);
        repeat (40) @(posedge i_clk);
        sender_hold = 1'b1;
        wait_drained();
        sender_hold = 1'b0;

        write_chunk_mask(BW'($urandom_range(1, 254)));
        queue_random(35);

        write_chunk_mask(phve_pkg::MASK_RESET);
        queue_random(40);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
